/* sv/sidsi_pkg.sv */
// Shared types and constants for the sorted identifier set.
// No dependencies.
package sidsi_pkg;

  localparam int unsigned ID_W         = 16;
  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned CNT_OUT_W    = 5;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2
  } ins_status_e;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

/* sv/sorted_id_set_insert_lookup.sv */
// Top level of the sorted identifier set; depends on sidsi_pkg, sidsi_mem and sidsi_cmp.
// Lookup: an accept state, then a read state and a compare state per search probe (at most
// clog2(CAPACITY)+1 probes), then the result state on a hit, or miss and result states on a
// miss. Insert that stores: after the miss, the shift state moves entries from the insert point
// up one slot, highest first, and the put state writes the new identifier. One beat at a time.
// Result is registered; the next beat is taken while it waits. Reset clears count and control.
module sorted_id_set_insert_lookup #(
  parameter int unsigned CAPACITY = sidsi_pkg::CAPACITY_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [sidsi_pkg::ID_W-1:0] node_id_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       found_o,
  output logic [sidsi_pkg::POS_W-1:0] position_o,
  output logic [1:0]                 insert_status_o,
  output logic [sidsi_pkg::CNT_OUT_W-1:0] entry_count_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_MISS,
    S_SHIFT,
    S_PUT,
    S_FIN
  } state_e;

  state_e                   state_q;
  logic                     act_q;
  logic [sidsi_pkg::ID_W-1:0] id_q;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         lo_q;
  logic [CNT_W-1:0]         hi_q;
  logic [IDX_W-1:0]         mid_q;
  logic [CNT_W-1:0]         j_q;
  logic [IDX_W-1:0]         prev_q;
  logic                     pend_q;
  logic                     last_q;
  logic                     res_found_q;
  logic [IDX_W-1:0]         res_pos_q;
  sidsi_pkg::ins_status_e   res_status_q;
  logic                     out_valid_q;
  logic                     out_found_q;
  logic [sidsi_pkg::POS_W-1:0] out_pos_q;
  sidsi_pkg::ins_status_e   out_status_q;
  logic [sidsi_pkg::CNT_OUT_W-1:0] out_count_q;

  logic [CNT_W-1:0]         mid_w;
  logic [CNT_W-1:0]         lo_nx;
  logic [CNT_W-1:0]         hi_nx;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [sidsi_pkg::ID_W-1:0] mem_wdata;
  logic [IDX_W-1:0]         mem_raddr;
  logic [sidsi_pkg::ID_W-1:0] mem_rdata;
  sidsi_pkg::cmp_res_t      cmp_res;

  assign mid_w = lo_q + ((hi_q - lo_q) >> 1);
  assign lo_nx = cmp_res.lt ? (CNT_W'(mid_q) + 1'b1) : lo_q;
  assign hi_nx = cmp_res.lt ? hi_q : CNT_W'(mid_q);

  always_comb begin
    mem_raddr = (state_q == S_SHIFT) ? j_q[IDX_W-1:0] : mid_w[IDX_W-1:0];
    mem_we    = ((state_q == S_SHIFT) && pend_q) || (state_q == S_PUT);
    if (state_q == S_PUT) begin
      mem_waddr = lo_q[IDX_W-1:0];
      mem_wdata = id_q;
    end else begin
      mem_waddr = prev_q + 1'b1;
      mem_wdata = mem_rdata;
    end
  end

  sidsi_mem #(
    .DEPTH  (CAPACITY),
    .DATA_W (sidsi_pkg::ID_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sidsi_cmp u_cmp (
    .a_i   (mem_rdata),
    .b_i   (id_q),
    .res_o (cmp_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      pend_q       <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      if ((state_q == S_FIN) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q        <= action_i;
            id_q         <= node_id_i;
            lo_q         <= '0;
            hi_q         <= count_q;
            res_found_q  <= 1'b0;
            res_pos_q    <= '0;
            res_status_q <= sidsi_pkg::ST_INSERTED;
            state_q      <= (count_q == '0) ? S_MISS : S_RD;
          end
        end
        S_RD: begin
          mid_q   <= mid_w[IDX_W-1:0];
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (cmp_res.eq) begin
            if (act_q == sidsi_pkg::ACT_INSERT) begin
              res_status_q <= sidsi_pkg::ST_PRESENT;
            end else begin
              res_found_q <= 1'b1;
              res_pos_q   <= mid_q;
            end
            state_q <= S_FIN;
          end else begin
            lo_q    <= lo_nx;
            hi_q    <= hi_nx;
            state_q <= (lo_nx < hi_nx) ? S_RD : S_MISS;
          end
        end
        S_MISS: begin
          if (act_q == sidsi_pkg::ACT_LOOKUP) begin
            state_q <= S_FIN;
          end else if (count_q >= CNT_W'(CAPACITY)) begin
            res_status_q <= sidsi_pkg::ST_FULL;
            state_q      <= S_FIN;
          end else if (lo_q == count_q) begin
            state_q <= S_PUT;
          end else begin
            j_q     <= count_q - 1'b1;
            pend_q  <= 1'b0;
            last_q  <= 1'b0;
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (last_q) begin
            state_q <= S_PUT;
          end else begin
            prev_q <= j_q[IDX_W-1:0];
            pend_q <= 1'b1;
            if (j_q == lo_q) begin
              last_q <= 1'b1;
            end else begin
              j_q <= j_q - 1'b1;
            end
          end
        end
        S_PUT: begin
          count_q <= count_q + 1'b1;
          pend_q  <= 1'b0;
          last_q  <= 1'b0;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_found_q  <= res_found_q;
            out_pos_q    <= sidsi_pkg::POS_W'(res_pos_q);
            out_status_q <= res_status_q;
            out_count_q  <= sidsi_pkg::CNT_OUT_W'(count_q);
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign found_o         = out_found_q;
  assign position_o      = out_pos_q;
  assign insert_status_o = out_status_q;
  assign entry_count_o   = out_count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == CNT_W'($past(count_q) + 1'b1)))
    else $error("entry count moved by more than one");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (insert_status_o == sidsi_pkg::ST_FULL))
      |-> (entry_count_o == sidsi_pkg::CNT_OUT_W'(CAPACITY)))
    else $error("full status reported below capacity");

  a_found_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (insert_status_o == sidsi_pkg::ST_INSERTED))
    else $error("found flag with insert status");
`endif

endmodule

/* sv/sidsi_mem.sv */
// Identifier store: one write port, one read port with registered read data.
// Uses no package items.
module sidsi_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/sidsi_cmp.sv */
// Shared identifier comparator used by every search probe.
// Depends on sidsi_pkg.
module sidsi_cmp (
  input  logic [sidsi_pkg::ID_W-1:0] a_i,
  input  logic [sidsi_pkg::ID_W-1:0] b_i,
  output sidsi_pkg::cmp_res_t        res_o
);

  always_comb begin
    res_o.eq = (a_i == b_i);
    res_o.lt = (a_i < b_i);
  end

endmodule
